// ===== src/bgt_pkg.sv =====
// ----------------------------------------------------------------------------
// bgt_pkg
// Shared types and constants for the biallelic genotype tally core.
// ----------------------------------------------------------------------------
package bgt_pkg;

  localparam int CODE_W = 16;
  localparam int OUT_W  = 16;

  localparam logic [CODE_W-1:0] MISSING_CODE = 16'hFFFF;
  localparam logic [CODE_W-1:0] HIGH_BYTE    = 16'hFF00;
  localparam logic [CODE_W-1:0] LOW_BYTE     = 16'h00FF;

  // Slot select / found mask bits
  localparam int NUM_SLOTS = 3;
  localparam logic [NUM_SLOTS-1:0] SLOT_NONE = 3'b000;
  localparam logic [NUM_SLOTS-1:0] SLOT_HOM1 = 3'b001;
  localparam logic [NUM_SLOTS-1:0] SLOT_HET  = 3'b010;
  localparam logic [NUM_SLOTS-1:0] SLOT_HOM2 = 3'b100;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              missing;
    logic              hom;
    logic              last;
  } item_t;

endpackage

// ===== src/bgt_in_if.sv =====
// ----------------------------------------------------------------------------
// bgt_in_if
// Input channel: one genotype code per item.
// ----------------------------------------------------------------------------
interface bgt_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] genotype_code;
  logic        last_in_row;

  modport source (output valid, output genotype_code, output last_in_row, input ready);
  modport sink   (input valid, input genotype_code, input last_in_row, output ready);
endinterface

// ===== src/bgt_out_if.sv =====
// ----------------------------------------------------------------------------
// bgt_out_if
// Result channel: per-row tallies, slot codes and error flag.
// ----------------------------------------------------------------------------
interface bgt_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] missing_count;
  logic [15:0] hom_first_count;
  logic [15:0] het_count;
  logic [15:0] hom_second_count;
  logic [15:0] hom_first_code;
  logic [15:0] het_code;
  logic [15:0] hom_second_code;
  logic        bad_row;

  modport source (
    output valid, input ready,
    output missing_count, output hom_first_count, output het_count,
    output hom_second_count, output hom_first_code, output het_code,
    output hom_second_code, output bad_row
  );
  modport sink (
    input valid, output ready,
    input missing_count, input hom_first_count, input het_count,
    input hom_second_count, input hom_first_code, input het_code,
    input hom_second_code, input bad_row
  );
endinterface

// ===== src/biallelic_genotype_tally_core.sv =====
// ----------------------------------------------------------------------------
// biallelic_genotype_tally_core
// Per-row genotype tally: missing count, three discovered slots, error flag.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; the back stage stalls only when a last item
//   arrives while the previous row result is still unclaimed at the output.
// Result: an accepted last item first enters the queue; when the back stage pops
//   it, the row is tallied into the result register and the output valid is set.
// Reset (rst_n, synchronous): clears queue, tallies, slot flags, error flag
//   and the output valid; the block accepts items the cycle after reset.
module biallelic_genotype_tally_core #(
  parameter int COUNT_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  bgt_in_if.sink    in_ch,
  bgt_out_if.source out_ch
);

  logic           push;
  bgt_pkg::item_t push_item;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;
  bgt_pkg::item_t q_item;

  bgt_front u_front (
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  bgt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (q_item)
  );

  bgt_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_full))
    else $error("item pushed into full queue");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && q_item.last && out_ch.valid && !out_ch.ready))
    else $error("row result overwritten before taken");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_item.last) |=> out_ch.valid)
    else $error("last item did not produce a result");

  a_missing_not_hom: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !(push_item.missing && push_item.hom))
    else $error("missing code classified homozygous");

endmodule

// ===== src/bgt_front.sv =====
// ----------------------------------------------------------------------------
// bgt_front
// Accepts genotype items and classifies them as missing or homozygous.
// ----------------------------------------------------------------------------
module bgt_front (
  bgt_in_if.sink         in_ch,
  input  logic           q_full,
  output logic           push,
  output bgt_pkg::item_t push_item
);

  logic [7:0] hi_byte;
  logic [7:0] lo_byte;

  assign hi_byte = 8'((in_ch.genotype_code & bgt_pkg::HIGH_BYTE) >> 8);
  assign lo_byte = 8'(in_ch.genotype_code & bgt_pkg::LOW_BYTE);

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    push_item.code    = in_ch.genotype_code;
    push_item.missing = (in_ch.genotype_code == bgt_pkg::MISSING_CODE);
    push_item.hom     = !push_item.missing && (hi_byte == lo_byte);
    push_item.last    = in_ch.last_in_row;
  end

endmodule

// ===== src/bgt_queue.sv =====
// ----------------------------------------------------------------------------
// bgt_queue
// Two-entry item queue between front and back; push and pop in the same cycle.
// ----------------------------------------------------------------------------
module bgt_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bgt_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output bgt_pkg::item_t pop_item
);

  bgt_pkg::item_t                  mem_r [bgt_pkg::QDEPTH];
  logic [bgt_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [bgt_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [bgt_pkg::QCNT_W-1:0]      count_r;
  logic [bgt_pkg::QCNT_W-1:0]      count_nxt;

  assign full      = (count_r == bgt_pkg::QCNT_W'(bgt_pkg::QDEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == bgt_pkg::QPTR_W'(bgt_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == bgt_pkg::QPTR_W'(bgt_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== src/bgt_back.sv =====
// ----------------------------------------------------------------------------
// bgt_back
// Matches codes against the three slots, tallies, and registers the result.
// ----------------------------------------------------------------------------
module bgt_back #(
  parameter int COUNT_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  bgt_pkg::item_t q_item,
  output logic           q_pop,
  bgt_out_if.source      out_ch
);

  localparam int NS = bgt_pkg::NUM_SLOTS;

  logic [NS-1:0]                 found_r;
  logic [NS-1:0]                 found_nxt;
  logic [bgt_pkg::CODE_W-1:0]    codes_r   [NS];
  logic [bgt_pkg::CODE_W-1:0]    codes_nxt [NS];
  logic [COUNT_BITS-1:0]         cnt_r     [NS];
  logic [COUNT_BITS-1:0]         cnt_nxt   [NS];
  logic [COUNT_BITS-1:0]         miss_r;
  logic [COUNT_BITS-1:0]         miss_nxt;
  logic                          err_r;
  logic                          err_nxt;
  logic [NS-1:0]                 match;
  logic [NS-1:0]                 sel;
  logic                          out_valid_r;

  // index 0 is missing tally, 1..3 are slot counts
  logic [COUNT_BITS-1:0]         clamp_in  [NS+1];
  logic [bgt_pkg::OUT_W-1:0]     clamp_out [NS+1];

  logic [bgt_pkg::OUT_W-1:0]     o_cnt_r   [NS+1];
  logic [bgt_pkg::CODE_W-1:0]    o_code_r  [NS];
  logic                          o_bad_r;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (v == '1) ? v : v + 1'b1;
  endfunction

  assign q_pop = q_valid && (!q_item.last || !out_valid_r || out_ch.ready);

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      match[k] = found_r[k] && (codes_r[k] == q_item.code);
    end
  end

  always_comb begin
    sel = bgt_pkg::SLOT_NONE;
    if (|match) begin
      sel = match;
    end else begin
      unique case (found_r)
        bgt_pkg::SLOT_NONE:
          sel = q_item.hom ? bgt_pkg::SLOT_HOM1 : bgt_pkg::SLOT_HET;
        bgt_pkg::SLOT_HOM1:
          sel = q_item.hom ? bgt_pkg::SLOT_HOM2 : bgt_pkg::SLOT_HET;
        bgt_pkg::SLOT_HET:
          sel = q_item.hom ? bgt_pkg::SLOT_HOM1 : bgt_pkg::SLOT_NONE;
        bgt_pkg::SLOT_HOM1 | bgt_pkg::SLOT_HET:
          sel = q_item.hom ? bgt_pkg::SLOT_HOM2 : bgt_pkg::SLOT_NONE;
        bgt_pkg::SLOT_HOM1 | bgt_pkg::SLOT_HOM2:
          sel = q_item.hom ? bgt_pkg::SLOT_NONE : bgt_pkg::SLOT_HET;
        default:
          sel = bgt_pkg::SLOT_NONE;
      endcase
    end
  end

  always_comb begin
    found_nxt = found_r;
    codes_nxt = codes_r;
    cnt_nxt   = cnt_r;
    miss_nxt  = miss_r;
    err_nxt   = err_r;
    if (q_item.missing) begin
      miss_nxt = sat_inc(miss_r);
    end else if (sel == bgt_pkg::SLOT_NONE) begin
      err_nxt = 1'b1;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (sel[k]) begin
          found_nxt[k] = 1'b1;
          codes_nxt[k] = q_item.code;
          cnt_nxt[k]   = sat_inc(cnt_r[k]);
        end
      end
    end
  end

  always_comb begin
    clamp_in[0] = miss_nxt;
    for (int k = 0; k < NS; k++) begin
      clamp_in[k+1] = cnt_nxt[k];
    end
  end

  for (genvar g = 0; g <= NS; g++) begin : g_clamp
    if (COUNT_BITS > bgt_pkg::OUT_W) begin : g_wide
      assign clamp_out[g] = (|clamp_in[g][COUNT_BITS-1:bgt_pkg::OUT_W]) ?
                            '1 : clamp_in[g][bgt_pkg::OUT_W-1:0];
    end else begin : g_narrow
      assign clamp_out[g] = bgt_pkg::OUT_W'(clamp_in[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r     <= '0;
      cnt_r       <= '{default: '0};
      miss_r      <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop && q_item.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop) begin
        if (q_item.last) begin
          found_r     <= '0;
          cnt_r       <= '{default: '0};
          miss_r      <= '0;
          err_r       <= 1'b0;
        end else begin
          found_r <= found_nxt;
          cnt_r   <= cnt_nxt;
          miss_r  <= miss_nxt;
          err_r   <= err_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      codes_r <= codes_nxt;
      if (q_item.last) begin
        o_cnt_r <= clamp_out;
        o_bad_r <= err_nxt;
        for (int k = 0; k < NS; k++) begin
          o_code_r[k] <= found_nxt[k] ? codes_nxt[k] : '0;
        end
      end
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.missing_count    = o_cnt_r[0];
  assign out_ch.hom_first_count  = o_cnt_r[1];
  assign out_ch.het_count        = o_cnt_r[2];
  assign out_ch.hom_second_count = o_cnt_r[3];
  assign out_ch.hom_first_code   = o_code_r[0];
  assign out_ch.het_code         = o_code_r[1];
  assign out_ch.hom_second_code  = o_code_r[2];
  assign out_ch.bad_row          = o_bad_r;

endmodule
